/* hw/rtl/bfcg_pkg.sv */
// Package for the band-pass FIR tap generator.
// Holds the tap limit, fixed-point constants, sequencer states and the series reciprocal table.
// No dependencies.
package bfcg_pkg;

    localparam int MAX_TAPS = 64;
    localparam int TAP_W    = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int M_W      = TAP_W + 2;

    localparam logic [63:0] PIHALF_Q62      = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;
    localparam logic [33:0] COEF_MAX        = 34'h1FFFFFFFF;
    localparam logic [33:0] COEF_MIN        = 34'h200000000;

    localparam logic [2:0] MUL_LAST = 3'd5;
    localparam logic [6:0] DIV_LAST = 7'd64;
    localparam logic [3:0] TERMS    = 4'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TDIV,
        S_CHECK,
        S_TAP,
        S_SIN_RED,
        S_TH_MUL,
        S_TH2_MUL,
        S_TERM_MUL,
        S_TERM_RCP,
        S_ACCUM,
        S_SIN_END,
        S_E_MUL,
        S_FDIV,
        S_FIN,
        S_OUT
    } t_state;

    // 2k(2k+1) = 2^pre * odd; divide by shifting right by pre, then multiply by
    // ceil(2^post / odd) and shift right by post
    function automatic logic [2:0] series_pre(input logic [3:0] k);
        logic [2:0] s;
        unique case (k)
            4'd1:    s = 3'd1;
            4'd2:    s = 3'd2;
            4'd3:    s = 3'd1;
            4'd4:    s = 3'd3;
            4'd5:    s = 3'd1;
            4'd6:    s = 3'd2;
            4'd7:    s = 3'd1;
            4'd8:    s = 3'd4;
            4'd9:    s = 3'd1;
            4'd10:   s = 3'd2;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] series_post(input logic [3:0] k);
        logic [6:0] s;
        unique case (k)
            4'd1:    s = 7'd65;
            4'd2:    s = 7'd66;
            4'd3:    s = 7'd68;
            4'd4:    s = 7'd67;
            4'd5:    s = 7'd69;
            4'd6:    s = 7'd69;
            4'd7:    s = 7'd70;
            4'd8:    s = 7'd68;
            4'd9:    s = 7'd71;
            4'd10:   s = 7'd70;
            default: s = 7'd0;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] series_rcp(input logic [3:0] k);
        logic [63:0] r;
        unique case (k)
            4'd1:    r = 64'(((128'd1 << 65) / 128'd3) + 128'd1);
            4'd2:    r = 64'(((128'd1 << 66) / 128'd5) + 128'd1);
            4'd3:    r = 64'(((128'd1 << 68) / 128'd21) + 128'd1);
            4'd4:    r = 64'(((128'd1 << 67) / 128'd9) + 128'd1);
            4'd5:    r = 64'(((128'd1 << 69) / 128'd55) + 128'd1);
            4'd6:    r = 64'(((128'd1 << 69) / 128'd39) + 128'd1);
            4'd7:    r = 64'(((128'd1 << 70) / 128'd105) + 128'd1);
            4'd8:    r = 64'(((128'd1 << 68) / 128'd17) + 128'd1);
            4'd9:    r = 64'(((128'd1 << 71) / 128'd171) + 128'd1);
            4'd10:   r = 64'(((128'd1 << 70) / 128'd105) + 128'd1);
            default: r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/bandpass_fir_coefficient_generator.sv */
// Band-pass FIR tap generator, rectangular-window sinc design. Depends on bfcg_pkg.
// One sequencer drives a shared 32x32 multiplier and a shared radix-2 restoring divider.
// The window length comes from a division and a check; then each tap is computed in
// turn (two Taylor-series sines, one division), and the centre tap skips both. One
// request at a time: input ready only in idle. Synchronous active-low reset returns
// to idle with no word pending.
module bandpass_fir_coefficient_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [16:0] i_lobe_width,
    input  logic [16:0] i_band_width,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_tap_index,
    output logic [33:0] o_coefficient,
    output logic [6:0]  o_tap_count,
    output logic        o_last,
    output logic        o_error
);
    import bfcg_pkg::*;

    t_state r_state, n_state;

    logic [6:0]   r_cnt;
    logic [16:0]  r_w, r_b;
    logic [CNT_W-1:0] r_taps;
    logic [TAP_W-1:0] r_j;
    logic         r_which, r_neg, r_s;
    logic [17:0]  r_u;
    logic [3:0]   r_k;
    logic [63:0]  r_term, r_th2;
    logic signed [63:0] r_sum, r_sd, r_sc;

    logic [63:0]  r_ma, r_mb, r_pp;
    logic [127:0] r_acc;
    logic [63:0]  r_dnum;
    logic [16:0]  r_rem, r_dvs;

    logic [5:0]   r_o_idx;
    logic [33:0]  r_o_coef;
    logic [6:0]   r_o_cnt;
    logic         r_o_last, r_o_err;

    logic mul_done, div_done;
    logic [CNT_W-1:0] n_ord;
    logic signed [M_W-1:0] m;
    logic [M_W-1:0] am;
    logic [63:0]  mq;
    logic [63:0]  rcp_q;
    logic [1:0]   pair, prev;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_sh;
    logic [17:0]  rem2;
    logic         q_bit;
    logic [18:0]  f19, m19, p19;
    logic [17:0]  u18;
    logic signed [63:0] mag, sval, diff;
    logic [64:0]  num65;
    logic [33:0]  fin_coef;

    assign mul_done = (r_cnt[2:0] == MUL_LAST);
    assign div_done = (r_cnt == DIV_LAST);
    assign n_ord    = r_taps - CNT_W'(1);
    assign m        = $signed({1'b0, r_j, 1'b0})
                    - $signed({{(M_W - CNT_W){1'b0}}, n_ord});
    assign am       = m[M_W-1] ? M_W'(-m) : M_W'(m);
    assign mq       = r_acc[125:62];
    assign rcp_q    = 64'(r_acc >> series_post(r_k));

    assign pair   = 2'(r_cnt - 7'd1);
    assign prev   = 2'(r_cnt - 7'd2);
    assign a_half = pair[1] ? r_ma[63:32] : r_ma[31:0];
    assign b_half = pair[0] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        unique case (prev)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    assign rem2  = {r_rem, r_dnum[63]};
    assign q_bit = (rem2 >= {1'b0, r_dvs});

    assign f19 = r_which ? 19'(19'd65536 - 19'(r_b)) : 19'(19'd65536 + 19'(r_b));
    assign m19 = 19'(m);
    assign p19 = 19'(f19 * m19);
    assign u18 = (p19[17:0] > 18'd131072) ? 18'(18'd0 - p19[17:0]) : p19[17:0];

    assign mag  = r_sum[63] ? 64'sd0 : (r_sum >>> 1);
    assign sval = r_neg ? -mag : mag;
    assign diff = r_sd - r_sc;

    assign num65 = {1'b0, r_acc[127:64]} + (65'(am) << 28) - 65'(r_s);

    always_comb begin
        if (r_s) begin
            fin_coef = (r_dnum > 64'h200000000) ? COEF_MIN : 34'(64'd0 - r_dnum);
        end else begin
            fin_coef = (r_dnum > 64'(COEF_MAX)) ? COEF_MAX : r_dnum[33:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_lobe_width == 17'd0) ? S_OUT : S_TDIV;
                end
            end
            S_TDIV:     if (div_done) n_state = S_CHECK;
            S_CHECK:    n_state = (r_dnum > 64'(MAX_TAPS)) ? S_OUT : S_TAP;
            S_TAP:      n_state = (m == '0) ? S_OUT : S_SIN_RED;
            S_SIN_RED:  n_state = S_TH_MUL;
            S_TH_MUL:   if (mul_done) n_state = S_TH2_MUL;
            S_TH2_MUL:  if (mul_done) n_state = S_TERM_MUL;
            S_TERM_MUL: if (mul_done) n_state = S_TERM_RCP;
            S_TERM_RCP: if (mul_done) n_state = S_ACCUM;
            S_ACCUM:    n_state = (r_k == TERMS) ? S_SIN_END : S_TERM_MUL;
            S_SIN_END:  n_state = r_which ? S_E_MUL : S_SIN_RED;
            S_E_MUL:    if (mul_done) n_state = S_FDIV;
            S_FDIV:     if (div_done) n_state = S_FIN;
            S_FIN:      n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = r_o_last ? S_IDLE : S_TAP;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready       = (r_state == S_IDLE);
        o_valid       = (r_state == S_OUT);
        o_tap_index   = r_o_idx;
        o_coefficient = r_o_coef;
        o_tap_count   = r_o_cnt;
        o_last        = r_o_last;
        o_error       = r_o_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_TH_MUL) || (r_state == S_TH2_MUL)
                || (r_state == S_TERM_MUL) || (r_state == S_TERM_RCP)
                || (r_state == S_E_MUL)) begin
                r_cnt <= mul_done ? 7'd0 : 7'(r_cnt + 7'd1);
            end else if ((r_state == S_TDIV) || (r_state == S_FDIV)) begin
                r_cnt <= div_done ? 7'd0 : 7'(r_cnt + 7'd1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // shared multiplier: load at step 0, partial products at 1..4, accumulate at 2..5
    always_ff @(posedge i_clk) begin
        if ((r_state == S_TH_MUL) || (r_state == S_TH2_MUL)
            || (r_state == S_TERM_MUL) || (r_state == S_TERM_RCP)
            || (r_state == S_E_MUL)) begin
            if (r_cnt == 7'd0) begin
                r_acc <= '0;
            end else begin
                if (r_cnt <= 7'd4) r_pp <= {32'd0, a_half} * {32'd0, b_half};
                if (r_cnt >= 7'd2) r_acc <= r_acc + pp_sh;
            end
        end
    end

    // shared divider: load at step 0, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if ((r_state == S_TDIV) || (r_state == S_FDIV)) begin
            if (r_cnt == 7'd0) begin
                r_rem <= '0;
                unique case (r_state)
                    S_TDIV: begin
                        r_dnum <= 64'(19'd262143 + 19'(r_w));
                        r_dvs  <= r_w;
                    end
                    default: begin
                        r_dnum <= 64'(num65[64:29]);
                        r_dvs  <= 17'(am);
                    end
                endcase
            end else begin
                r_rem  <= q_bit ? 17'(rem2 - {1'b0, r_dvs}) : rem2[16:0];
                r_dnum <= {r_dnum[62:0], q_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_w      <= i_lobe_width;
                r_b      <= i_band_width;
                r_o_idx  <= '0;
                r_o_coef <= '0;
                r_o_cnt  <= '0;
                r_o_last <= 1'b1;
                r_o_err  <= 1'b1;
            end
            S_CHECK: begin
                r_taps <= CNT_W'(r_dnum);
                r_j    <= '0;
            end
            S_TAP: begin
                r_which  <= 1'b0;
                r_o_idx  <= 6'(r_j);
                r_o_cnt  <= 7'(r_taps);
                r_o_last <= (CNT_W'(r_j) == n_ord);
                r_o_err  <= 1'b0;
                r_o_coef <= {r_b, 17'd0} >> 1;
            end
            S_SIN_RED: begin
                r_neg <= p19[18];
                r_u   <= u18;
                r_k   <= 4'd1;
            end
            S_TH_MUL: begin
                if (r_cnt == 7'd0) begin
                    r_ma <= PIHALF_Q62;
                    r_mb <= 64'(r_u) << 45;
                end
            end
            S_TH2_MUL: begin
                if (r_cnt == 7'd0) begin
                    r_ma   <= mq;
                    r_mb   <= mq;
                    r_term <= mq;
                    r_sum  <= $signed(mq);
                end
            end
            S_TERM_MUL: begin
                if (r_cnt == 7'd0) begin
                    r_ma <= r_term;
                    if (r_k == 4'd1) begin
                        r_th2 <= mq;
                        r_mb  <= mq;
                    end else begin
                        r_mb <= r_th2;
                    end
                end
            end
            S_TERM_RCP: begin
                if (r_cnt == 7'd0) begin
                    r_ma <= mq >> series_pre(r_k);
                    r_mb <= series_rcp(r_k);
                end
            end
            S_ACCUM: begin
                r_term <= rcp_q;
                r_sum  <= r_k[0] ? (r_sum - $signed(rcp_q)) : (r_sum + $signed(rcp_q));
                r_k    <= 4'(r_k + 4'd1);
            end
            S_SIN_END: begin
                if (r_which) begin
                    r_sc <= sval;
                end else begin
                    r_sd    <= sval;
                    r_which <= 1'b1;
                end
            end
            S_E_MUL: begin
                if (r_cnt == 7'd0) begin
                    r_ma <= diff[63] ? 64'(-diff) : 64'(diff);
                    r_mb <= TWO_OVER_PI_Q64;
                    r_s  <= diff[63] ^ m[M_W-1];
                end
            end
            S_FIN: begin
                r_o_coef <= fin_coef;
            end
            S_OUT: begin
                if (i_ready && !r_o_last) begin
                    r_j <= TAP_W'(r_j + TAP_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

endmodule
